[src/dgr_pkg.sv]
package dgr_pkg;

	localparam int unsigned MaxVerticesDefault = 64;
	localparam int unsigned CmdW = 3;
	localparam int unsigned VidW = 6;
	localparam int unsigned CountW = 7;

	typedef enum logic [CmdW-1:0] {
		CMD_ADD_EDGE = 3'd0,
		CMD_DEL_EDGE = 3'd1,
		CMD_DEL_VERTEX = 3'd2,
		CMD_REACH = 3'd3,
		CMD_CYCLE = 3'd4
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_EDIT_RD,
		ST_EDIT_WR,
		ST_DELV,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [CmdW-1:0] cmd;
		logic [VidW-1:0] from_vertex;
		logic [VidW-1:0] to_vertex;
	} dgr_req_t;

	typedef struct packed {
		logic answer;
		logic [CountW-1:0] vertex_count;
	} dgr_rsp_t;

endpackage

[src/dgr_stream_if.sv]
interface dgr_stream_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[src/directed_graph_reachability_store.sv]
// channel | modport | payload
// req     | sink    | cmd, from_vertex, to_vertex
// rsp     | source  | answer, vertex_count
//
// After reset a clearing pass writes zero to every row; no requests are taken until it ends.
// Edits do one read and one write; vertex removal does one read+write per row.
// Queries sweep all rows, reading each row in the current set through the memory's one read port;
// a sweep repeats until a sweep makes no change.
// A result waits in an output register; one request is worked at a time.
module directed_graph_reachability_store #(
	parameter int unsigned MaxVertices = dgr_pkg::MaxVerticesDefault
) (
	input logic clk,
	input logic arst_n,
	dgr_stream_if.sink req,
	dgr_stream_if.source rsp
);
	import dgr_pkg::*;

	localparam int unsigned AW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
	localparam int unsigned CW = $clog2(MaxVertices + 1);

	state_t state_q, state_d;
	logic [AW:0] idx_q, idx_d;
	logic [CmdW-1:0] cmd_q;
	logic [VidW-1:0] from_q, to_q;
	logic [MaxVertices-1:0] present_q, present_d;
	logic [CW-1:0] count_q, count_d;
	logic [MaxVertices-1:0] set_q, set_d; // reached or remaining set
	logic changed_q, changed_d;
	logic rsp_valid_q, rsp_valid_d, answer_q, answer_d;
	logic from_ok, to_ok;

	logic rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [MaxVertices-1:0] rd_data, wr_data;

	dgr_adj_mem #(.NumVertices(MaxVertices), .AddrW(AW)) u_mem (
		.clk, .rd_en, .rd_addr, .rd_data, .wr_en, .wr_addr, .wr_data
	);

	// vertex ids may be wider than the address when MaxVertices is small
	assign from_ok = ({{(32-VidW){1'b0}}, from_q} < MaxVertices);
	assign to_ok = ({{(32-VidW){1'b0}}, to_q} < MaxVertices);

	logic [AW-1:0] from_a, to_a, idx_a;
	assign from_a = AW'(from_q);
	assign to_a = AW'(to_q);
	assign idx_a = idx_q[AW-1:0];

	assign req.ready = (state_q == ST_IDLE) && !rsp_valid_q;
	assign rsp.valid = rsp_valid_q;
	assign rsp.payload.answer = answer_q;
	assign rsp.payload.vertex_count = CountW'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			idx_q <= '0;
			present_q <= '0;
			count_q <= '0;
			rsp_valid_q <= 1'b0;
			changed_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			present_q <= present_d;
			count_q <= count_d;
			rsp_valid_q <= rsp_valid_d;
			changed_q <= changed_d;
		end
	end

	always_ff @(posedge clk) begin
		answer_q <= answer_d;
		set_q <= set_d;
		if (req.valid && req.ready) begin
			cmd_q <= req.payload.cmd;
			from_q <= req.payload.from_vertex;
			to_q <= req.payload.to_vertex;
		end
	end

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		present_d = present_q;
		count_d = count_q;
		set_d = set_q;
		changed_d = changed_q;
		rsp_valid_d = rsp_valid_q && !rsp.ready;
		answer_d = answer_q;
		rd_en = 1'b0;
		rd_addr = idx_a;
		wr_en = 1'b0;
		wr_addr = idx_a;
		wr_data = rd_data;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
				wr_data = '0;
				idx_d = idx_q + (AW+1)'(1);
				if (idx_q == (AW+1)'(MaxVertices - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req.valid && req.ready) begin
					state_d = ST_EDIT_RD;
				end
			end
			ST_EDIT_RD: begin
				answer_d = 1'b0;
				idx_d = '0;
				changed_d = 1'b0;
				unique case (cmd_q)
					CMD_ADD_EDGE, CMD_DEL_EDGE: begin
						if (from_ok && to_ok) begin
							rd_en = 1'b1;
							rd_addr = from_a;
							state_d = ST_EDIT_WR;
						end else begin
							state_d = ST_DONE;
						end
					end
					CMD_DEL_VERTEX: begin
						state_d = (from_ok && present_q[from_a]) ? ST_DELV : ST_DONE;
						if (from_ok && present_q[from_a]) begin
							rd_en = 1'b1;
							rd_addr = '0;
						end
					end
					CMD_REACH: begin
						// seed: reached set is row from, fetched by first sweep trick
						if (from_ok && to_ok) begin
							rd_en = 1'b1;
							rd_addr = from_a;
							set_d = '0;
							state_d = ST_SCAN_EV;
							changed_d = 1'b1;
							idx_d = (AW+1)'(MaxVertices); // marks seed load
						end else begin
							state_d = ST_DONE;
						end
					end
					CMD_CYCLE: begin
						set_d = present_q;
						state_d = ST_SCAN_RD;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_EDIT_WR: begin
				wr_en = 1'b1;
				wr_addr = from_a;
				wr_data = rd_data;
				wr_data[to_a] = (cmd_q == CMD_ADD_EDGE);
				if (cmd_q == CMD_ADD_EDGE) begin
					present_d[from_a] = 1'b1;
					present_d[to_a] = 1'b1;
					count_d = count_q + CW'(!present_q[from_a])
						+ CW'(!present_q[to_a] && (to_a != from_a));
				end
				state_d = ST_DONE;
			end
			ST_DELV: begin
				// rd_data holds row idx; write it back with column cleared (row from itself is zeroed)
				wr_en = 1'b1;
				wr_data = rd_data;
				wr_data[from_a] = 1'b0;
				if (idx_a == from_a) wr_data = '0;
				idx_d = idx_q + (AW+1)'(1);
				if (idx_q == (AW+1)'(MaxVertices - 1)) begin
					present_d[from_a] = 1'b0;
					count_d = count_q - CW'(1);
					state_d = ST_DONE;
				end else begin
					rd_en = 1'b1;
					rd_addr = AW'(idx_q + (AW+1)'(1));
				end
			end
			ST_SCAN_RD: begin
				if (idx_q == (AW+1)'(MaxVertices)) begin
					if (changed_q) begin
						idx_d = '0;
						changed_d = 1'b0;
					end else begin
						answer_d = (cmd_q == CMD_REACH) ? set_q[to_a] : |set_q;
						state_d = ST_DONE;
					end
				end else if (set_q[idx_a]) begin
					rd_en = 1'b1;
					state_d = ST_SCAN_EV;
				end else begin
					idx_d = idx_q + (AW+1)'(1);
				end
			end
			ST_SCAN_EV: begin
				state_d = ST_SCAN_RD;
				if (idx_q == (AW+1)'(MaxVertices)) begin
					set_d = rd_data; // reach seed
					idx_d = '0;
					changed_d = 1'b0;
				end else begin
					idx_d = idx_q + (AW+1)'(1);
					if (cmd_q == CMD_REACH) begin
						if ((set_q | rd_data) != set_q) begin
							set_d = set_q | rd_data;
							changed_d = 1'b1;
						end
					end else if ((rd_data & set_q) == '0) begin
						set_d[idx_a] = 1'b0;
						changed_d = 1'b1;
					end
				end
			end
			ST_DONE: begin
				rsp_valid_d = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

[src/dgr_adj_mem.sv]
module dgr_adj_mem #(
	parameter int unsigned NumVertices = dgr_pkg::MaxVerticesDefault,
	parameter int unsigned AddrW = $clog2(NumVertices)
) (
	input logic clk,
	input logic rd_en,
	input logic [AddrW-1:0] rd_addr,
	output logic [NumVertices-1:0] rd_data,
	input logic wr_en,
	input logic [AddrW-1:0] wr_addr,
	input logic [NumVertices-1:0] wr_data
);
	logic [NumVertices-1:0] mem [NumVertices];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

[src/dgr_checker.sv]
module dgr_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [6:0] rsp_count
);
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_count <= 7'd64) else $error("count out of range");
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready) else $error("accept while result pending");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !rsp_valid) else $error("early result");
endmodule

bind directed_graph_reachability_store dgr_checker u_dgr_checker (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_count(rsp.payload.vertex_count)
);
